// ===== rtl/htrle_pkg.sv =====
// Package for the Huffman tree decoder with run-length expansion.
// Holds function codes, queue entry and state types, and fixed constants.
// No dependencies.
`timescale 1ns / 1ps

package htrle_pkg;

    localparam logic [1:0] FUNC_BYTE    = 2'd0;
    localparam logic [1:0] FUNC_LOAD    = 2'd1;
    localparam logic [1:0] FUNC_RESTART = 2'd2;

    localparam logic [7:0] RUN_MARK = 8'h90;
    localparam logic [8:0] END_SYM  = 9'd256;
    localparam logic [9:0] END_LEAF = 10'h2FF;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_BYTE,
        KIND_LOAD,
        KIND_RESTART
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  data_byte;
        logic [7:0]  node_index;
        logic [9:0]  zero_child;
        logic [9:0]  one_child;
    } queue_entry_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_FLUSH = 3'b100
    } back_state_t;

    typedef struct packed {
        logic       [7:0] out_byte;
        logic       [7:0] repeat_res;
        logic             end_of_stream;
        logic             error;
    } result_t;

endpackage

// ===== rtl/htrle_ifs.sv =====
// Channel interfaces of the Huffman tree decoder: input items and result items.
// Valid/ready handshake with source and sink modports. No dependencies.
`timescale 1ns / 1ps

interface htrle_item_if;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [7:0]        compressed_byte;
    logic [7:0]        node_index;
    logic signed [9:0] zero_child;
    logic signed [9:0] one_child;

    modport source (
        output valid, func, compressed_byte, node_index, zero_child, one_child,
        input  ready
    );
    modport sink (
        input  valid, func, compressed_byte, node_index, zero_child, one_child,
        output ready
    );
endinterface

interface htrle_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [7:0] repeat_res;
    logic       end_of_stream;
    logic       error;
    logic       last;

    modport source (
        output valid, out_byte, repeat_res, end_of_stream, error, last,
        input  ready
    );
    modport sink (
        input  valid, out_byte, repeat_res, end_of_stream, error, last,
        output ready
    );
endinterface

// ===== rtl/htrle_queue.sv =====
// Short first-in first-out queue of classified items between front and back.
// Depends on htrle_pkg for the entry type and depth.
`timescale 1ns / 1ps

module htrle_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  htrle_pkg::queue_entry_t push_data,
    output logic                  full,
    input  logic                  pop,
    output htrle_pkg::queue_entry_t pop_data,
    output logic                  empty
);
    import htrle_pkg::*;

    queue_entry_t        slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/htrle_front.sv =====
// Front end: accepts input items, classifies them and queues the useful ones.
// Depends on htrle_pkg, htrle_ifs and htrle_queue.
`timescale 1ns / 1ps

module htrle_front #(
    parameter int TREE_NODES = 256
) (
    input  logic                   clk,
    input  logic                   rst_n,
    htrle_item_if.sink             items,
    input  logic                   pop,
    output htrle_pkg::queue_entry_t pop_data,
    output logic                   empty
);
    import htrle_pkg::*;

    queue_entry_t entry;
    logic         keep;
    logic         full;

    always_comb
    begin
        entry.kind       = KIND_BYTE;
        entry.data_byte  = items.compressed_byte;
        entry.node_index = items.node_index;
        entry.zero_child = items.zero_child;
        entry.one_child  = items.one_child;
        keep             = 1'b0;
        unique case (items.func)
            FUNC_BYTE:
            begin
                entry.kind = KIND_BYTE;
                keep       = 1'b1;
            end
            FUNC_LOAD:
            begin
                entry.kind = KIND_LOAD;
                keep       = ({1'b0, items.node_index} < 9'(TREE_NODES));
            end
            FUNC_RESTART:
            begin
                entry.kind = KIND_RESTART;
                keep       = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign items.ready = !full;

    htrle_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (items.valid && keep),
        .push_data (entry),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

endmodule

// ===== rtl/htrle_back.sv =====
// Back end: tree store, bit-serial tree walk, run-length stage and result register.
// Depends on htrle_pkg and htrle_ifs.
`timescale 1ns / 1ps

module htrle_back #(
    parameter int TREE_NODES = 256
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [8:0]              cfg_wdata,
    output logic                    pop,
    input  htrle_pkg::queue_entry_t pop_data,
    input  logic                    empty,
    htrle_result_if.source          results
);
    import htrle_pkg::*;

    localparam int ADDR_W = (TREE_NODES > 1) ? $clog2(TREE_NODES) : 1;

    logic [19:0]       tree_mem [TREE_NODES];
    logic [19:0]       rd_data_reg;
    logic              rd_zero_reg;
    logic              node0_loaded_reg;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [8:0]        node_count_reg;
    logic [ADDR_W-1:0] walk_node_reg;
    logic [ADDR_W-1:0] walk_node_next;
    logic              awaiting_reg;
    logic              awaiting_next;
    logic [7:0]        prev_byte_reg;
    logic [7:0]        prev_byte_next;
    logic              ended_reg;
    logic              ended_next;
    logic [7:0]        byte_reg;
    logic [2:0]        bit_cnt_reg;
    logic [2:0]        bit_cnt_next;

    result_t           pend_reg;
    result_t           pend_next;
    logic              pend_valid_reg;
    logic              pend_valid_next;
    result_t           out_reg;
    result_t           out_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_last_reg;
    logic              out_last_next;
    logic              out_free;

    logic [9:0]        child;
    logic              is_node;
    logic              node_bad;
    logic [8:0]        sym;
    logic              res_fire;
    result_t           res;
    logic              end_now;
    logic              stall;
    logic              take_byte;
    logic              mem_we;

    assign out_free  = !out_valid_reg || results.ready;
    assign pop       = (state_reg == ST_IDLE) && !empty;
    assign take_byte = pop && (pop_data.kind == KIND_BYTE) && !ended_reg;
    assign mem_we    = pop && (pop_data.kind == KIND_LOAD);

    always_comb
    begin
        child = byte_reg[bit_cnt_reg] ? rd_data_reg[9:0] : rd_data_reg[19:10];
        if (rd_zero_reg && !node0_loaded_reg)
        begin
            child = END_LEAF;
        end
        is_node  = !child[9];
        node_bad = (child >= {1'b0, node_count_reg}) || (child >= 10'(TREE_NODES));
        sym      = ~child[8:0];
    end

    always_comb
    begin
        res_fire       = 1'b0;
        res            = '0;
        end_now        = 1'b0;
        walk_node_next = walk_node_reg;
        awaiting_next  = awaiting_reg;
        prev_byte_next = prev_byte_reg;
        if (is_node)
        begin
            if (node_bad)
            begin
                res_fire  = 1'b1;
                res.error = 1'b1;
                end_now   = 1'b1;
            end
            else
            begin
                walk_node_next = child[ADDR_W-1:0];
            end
        end
        else
        begin
            walk_node_next = '0;
            if (awaiting_reg)
            begin
                awaiting_next = 1'b0;
                res_fire      = 1'b1;
                if (sym == '0)
                begin
                    res.out_byte   = RUN_MARK;
                    res.repeat_res = 8'd1;
                end
                else if (sym < END_SYM)
                begin
                    res.out_byte   = prev_byte_reg;
                    res.repeat_res = (sym <= 9'd2) ? 8'd1 : 8'(sym - 9'd1);
                end
                else
                begin
                    res.error = 1'b1;
                    end_now   = 1'b1;
                end
            end
            else if (sym == {1'b0, RUN_MARK})
            begin
                awaiting_next = 1'b1;
            end
            else if (sym < END_SYM)
            begin
                prev_byte_next = sym[7:0];
                res_fire       = 1'b1;
                res.out_byte   = sym[7:0];
                res.repeat_res = 8'd1;
            end
            else if (sym == END_SYM)
            begin
                res_fire          = 1'b1;
                res.end_of_stream = 1'b1;
                end_now           = 1'b1;
            end
            else
            begin
                res_fire  = 1'b1;
                res.error = 1'b1;
                end_now   = 1'b1;
            end
        end
    end

    assign stall = res_fire && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next      = state_reg;
        bit_cnt_next    = bit_cnt_reg;
        ended_next      = ended_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !results.ready;
        rd_en           = 1'b0;
        rd_addr         = walk_node_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take_byte)
                begin
                    rd_en        = 1'b1;
                    bit_cnt_next = '0;
                    state_next   = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (!stall)
                begin
                    if (res_fire)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_next       = pend_reg;
                            out_last_next  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                        pend_next       = res;
                        pend_valid_next = 1'b1;
                    end
                    if (end_now)
                    begin
                        ended_next = 1'b1;
                    end
                    if (end_now || (bit_cnt_reg == 3'd7))
                    begin
                        state_next = ST_FLUSH;
                    end
                    else
                    begin
                        rd_en        = 1'b1;
                        rd_addr      = walk_node_next;
                        bit_cnt_next = bit_cnt_reg + 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            node_count_reg   <= '0;
            walk_node_reg    <= '0;
            awaiting_reg     <= 1'b0;
            prev_byte_reg    <= '0;
            ended_reg        <= 1'b0;
            bit_cnt_reg      <= '0;
            pend_valid_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
            node0_loaded_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bit_cnt_reg    <= bit_cnt_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (mem_we && (pop_data.node_index == 8'd0))
            begin
                node0_loaded_reg <= 1'b1;
            end
            if (pop && (pop_data.kind == KIND_RESTART))
            begin
                walk_node_reg <= '0;
                awaiting_reg  <= 1'b0;
                prev_byte_reg <= '0;
                ended_reg     <= 1'b0;
            end
            else if ((state_reg == ST_WALK) && !stall)
            begin
                walk_node_reg <= walk_node_next;
                awaiting_reg  <= awaiting_next;
                prev_byte_reg <= prev_byte_next;
                ended_reg     <= ended_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        if (take_byte)
        begin
            byte_reg <= pop_data.data_byte;
        end
        if (mem_we)
        begin
            tree_mem[pop_data.node_index[ADDR_W-1:0]] <= {pop_data.zero_child, pop_data.one_child};
        end
        if (rd_en)
        begin
            rd_data_reg <= tree_mem[rd_addr];
            rd_zero_reg <= (rd_addr == '0);
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.out_byte      = out_reg.out_byte;
    assign results.repeat_res    = out_reg.repeat_res;
    assign results.end_of_stream = out_reg.end_of_stream;
    assign results.error         = out_reg.error;
    assign results.last          = out_last_reg;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending result left over in idle");

    a_walk_not_ended: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> !ended_reg)
        else $error("tree walk running after stream end");

    a_end_err_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.end_of_stream && out_reg.error))
        else $error("result flagged both end and error");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.end_of_stream || out_reg.error)) |-> out_last_reg)
        else $error("end or error result not last of its item");
`endif

endmodule

// ===== rtl/huffman_tree_rle_unsqueezer_top.sv =====
// Top level of the Huffman tree decoder with run-length expansion.
// Depends on htrle_pkg, htrle_ifs, htrle_front and htrle_back.
`timescale 1ns / 1ps
//
// Usage:
//   items   : valid/ready channel of input items. func selects a compressed
//             byte, a tree node load or a restart of decoding.
//   results : valid/ready channel of decoded results (byte, repeat count,
//             end and error flags, last marks the final result of an item).
//   cfg_we / cfg_wdata : write of node_count; write only while idle.
// Operation:
//   A two-entry queue parts the accepting front from the decoding back.
//   A load or restart is handled in idle. A byte is taken while its current
//   node is read; then each of its eight bits is resolved, with the next node
//   read for all but the last; then the last result is handed over. An end
//   or error cuts it short. Results trail the walk by one find. The back
//   takes its next item only once idle again.
// Reset:
//   Clears node_count, the walk, the run-length state and all valid flags;
//   node 0 reads as two end leaves until loaded. Other nodes are undefined.
// Stall:
//   A held result blocks the walk at the next result; the queue then fills
//   and items.ready drops.

module huffman_tree_rle_unsqueezer_top #(
    parameter int TREE_NODES = 256
) (
    input  logic           clk,
    input  logic           rst_n,
    htrle_item_if.sink     items,
    htrle_result_if.source results,
    input  logic           cfg_we,
    input  logic [8:0]     cfg_wdata
);
    import htrle_pkg::*;

    queue_entry_t q_data;
    logic         q_empty;
    logic         q_pop;

    htrle_front #(
        .TREE_NODES (TREE_NODES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .items    (items),
        .pop      (q_pop),
        .pop_data (q_data),
        .empty    (q_empty)
    );

    htrle_back #(
        .TREE_NODES (TREE_NODES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty),
        .results   (results)
    );

endmodule
